// ----- rtl/core/fctu_pkg.sv -----
// shared types, codes and helpers of the function call trace unit
`default_nettype none

package fctu_pkg;

  // request op codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EXEC   = 2'd2;

  // record kinds
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  // jalr x0, 0(x1)
  localparam logic [31:0] RET_WORD = 32'h0000_8067;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned INST_W  = 32;
  localparam int unsigned FIDX_W  = 7;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned DEPTH_W = 8;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'h7F;

  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT0,
    ST_EMIT1
  } fctu_state_e;

  typedef struct packed {
    logic ready;      // take a request this cycle
    logic scan_step;  // read next table entry
    logic decide;     // settle records and counters
    logic load0;      // move first record to output register
    logic load1;      // move second record to output register
  } fctu_cmd_t;

  typedef struct packed {
    logic req_exec;   // valid executed-instruction request waiting
    logic count_zero;
    logic scan_last;
    logic dec_none;
    logic two_recs;
    logic out_free;
  } fctu_sts_t;

  typedef struct packed {
    logic               kind;
    logic [FIDX_W-1:0]  func_index;
    logic [ADDR_W-1:0]  record_pc;
    logic [LEVEL_W-1:0] call_level;
    logic               last;
  } fctu_rec_t;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [DEPTH_W-1:0] d);
    logic [LEVEL_W-1:0] r;
    r = (d > DEPTH_W'(LEVEL_MAX)) ? LEVEL_MAX : d[LEVEL_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fctu_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module fctu_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/fctu_ctrl.sv -----
// sequencing state machine of the function call trace unit
`default_nettype none

module fctu_ctrl
  import fctu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fctu_sts_t sts_i,
  output fctu_cmd_t      cmd_o
);

  fctu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.req_exec) begin
          state_d = sts_i.count_zero ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = sts_i.dec_none ? ST_IDLE : ST_EMIT0;
      ST_EMIT0: begin
        if (sts_i.out_free) begin
          state_d = sts_i.two_recs ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.ready = 1'b1;
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_DRAIN:  cmd_o = '0;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_EMIT0:  cmd_o.load0 = sts_i.out_free;
      ST_EMIT1:  cmd_o.load1 = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  a_drain_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ($past(state_q) == ST_SCAN))
    else $error("drain entered without a scan");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load0 || cmd_o.load1) |-> sts_i.out_free)
    else $error("record loaded over a pending result");

endmodule

`default_nettype wire

// ----- rtl/core/fctu_dp.sv -----
// table scan, counters and result register of the function call trace unit
`default_nettype none

module fctu_dp
  import fctu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128,
  parameter int RECORD_LIMIT  = 128,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fctu_cmd_t           cmd_i,
  output fctu_sts_t                sts_o,
  input  wire logic                req_valid_i,
  input  wire logic [1:0]          req_op_i,
  input  wire logic [ADDR_W-1:0]   req_pc_i,
  input  wire logic [INST_W-1:0]   req_inst_i,
  input  wire logic [ADDR_W-1:0]   req_start_i,
  input  wire logic [ADDR_W-1:0]   req_length_i,
  output logic                     ram_we_o,
  output logic                     ram_re_o,
  output logic [IW-1:0]            ram_addr_o,
  output logic [2*ADDR_W-1:0]      ram_wdata_o,
  input  wire logic [2*ADDR_W-1:0] ram_rdata_i,
  output logic                     out_valid_o,
  output fctu_rec_t                out_rec_o,
  input  wire logic                out_ready_i
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = $clog2(RECORD_LIMIT + 1);

  logic              fire;
  logic [CW-1:0]     count_q, count_d;
  logic [RW-1:0]     rc_q, rc_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [ADDR_W-1:0] pc_q;
  logic              ret_q;
  logic [IW-1:0]     scan_addr_q;
  logic              cmp_vld_q;
  logic [IW-1:0]     cmp_idx_q;
  logic              hit_q, found_q;
  logic [IW-1:0]     idx_q;
  fctu_rec_t         rec0_q, rec1_q;
  logic              two_q;
  logic              out_valid_q;
  fctu_rec_t         out_rec_q;

  logic [ADDR_W-1:0] ent_start, ent_length, ent_off;
  logic              ent_eq, ent_in;
  logic              entry_ok, ret_ok;
  logic [RW-1:0]     rc_mid;
  logic [DEPTH_W-1:0] depth1, depth2;
  logic              out_free;

  assign fire = cmd_i.ready && req_valid_i;

  // append write shares the port with the scan read
  assign ram_we_o    = fire && (req_op_i == OP_APPEND) && (req_length_i != '0) &&
                       (count_q < CW'(TABLE_ENTRIES));
  assign ram_re_o    = cmd_i.scan_step;
  assign ram_addr_o  = ram_we_o ? count_q[IW-1:0] : scan_addr_q;
  assign ram_wdata_o = {req_length_i, req_start_i};

  // range compare of the entry read last cycle
  assign ent_start  = ram_rdata_i[ADDR_W-1:0];
  assign ent_length = ram_rdata_i[2*ADDR_W-1:ADDR_W];
  assign ent_off    = pc_q - ent_start;
  assign ent_eq     = (pc_q == ent_start);
  assign ent_in     = (pc_q >= ent_start) && (ent_off < ent_length);

  // record decision
  assign entry_ok = hit_q && found_q && (rc_q < RW'(RECORD_LIMIT));
  assign rc_mid   = rc_q + RW'(entry_ok);
  assign ret_ok   = ret_q && found_q && (rc_mid < RW'(RECORD_LIMIT));
  assign depth1   = (entry_ok && (depth_q != DEPTH_MAX)) ? depth_q + 1'b1 : depth_q;
  assign depth2   = (ret_ok && (depth1 != '0)) ? depth1 - 1'b1 : depth1;

  always_comb begin
    count_d = count_q;
    rc_d    = rc_q;
    depth_d = depth_q;
    if (fire) begin
      case (req_op_i)
        OP_CLEAR: begin
          count_d = '0;
          rc_d    = '0;
          depth_d = '0;
        end
        OP_APPEND: begin
          if (ram_we_o) begin
            count_d = count_q + 1'b1;
          end
        end
        default: count_d = count_q;
      endcase
    end
    if (cmd_i.decide) begin
      rc_d    = rc_mid + RW'(ret_ok);
      depth_d = depth2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rc_q        <= '0;
      depth_q     <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rc_q      <= rc_d;
      depth_q   <= depth_d;
      cmp_vld_q <= cmd_i.scan_step;
      if (fire && (req_op_i == OP_EXEC)) begin
        hit_q   <= 1'b0;
        found_q <= 1'b0;
      end else if (cmp_vld_q) begin
        hit_q <= hit_q || ent_eq;
        if (!found_q && ent_in) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.decide) begin
        two_q <= entry_ok && ret_ok;
      end
      if (cmd_i.load0 || cmd_i.load1) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire && (req_op_i == OP_EXEC)) begin
      pc_q        <= req_pc_i;
      ret_q       <= (req_inst_i == RET_WORD);
      scan_addr_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_addr_q <= scan_addr_q + 1'b1;
    end
    if (cmd_i.scan_step) begin
      cmp_idx_q <= scan_addr_q;
    end
    if (cmp_vld_q && !found_q && ent_in) begin
      idx_q <= cmp_idx_q;
    end
    if (cmd_i.decide) begin
      rec0_q.kind       <= entry_ok ? KIND_ENTRY : KIND_EXIT;
      rec0_q.func_index <= FIDX_W'(idx_q);
      rec0_q.record_pc  <= pc_q;
      rec0_q.call_level <= entry_ok ? sat_level(depth_q) : sat_level(depth2);
      rec0_q.last       <= !(entry_ok && ret_ok);
      rec1_q.kind       <= KIND_EXIT;
      rec1_q.func_index <= FIDX_W'(idx_q);
      rec1_q.record_pc  <= pc_q;
      rec1_q.call_level <= sat_level(depth2);
      rec1_q.last       <= 1'b1;
    end
    if (cmd_i.load0) begin
      out_rec_q <= rec0_q;
    end else if (cmd_i.load1) begin
      out_rec_q <= rec1_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.req_exec   = req_valid_i && (req_op_i == OP_EXEC);
    sts_o.count_zero = (count_q == '0);
    sts_o.scan_last  = (CW'(scan_addr_q) == count_q - 1'b1);
    sts_o.dec_none   = !(entry_ok || ret_ok);
    sts_o.two_recs   = two_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("table count beyond table size");

  a_record_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RW'(RECORD_LIMIT))
    else $error("record count beyond limit");

endmodule

`default_nettype wire

// ----- rtl/core/function_call_trace_unit.sv -----
// top level of the function call trace unit
`default_nettype none

// Function-call tracer for a RISC-V core. Requests arrive on the slave stream with
// the op code in tuser: clear (empties the function table and resets record count
// and call depth), append (stores one function start address and size; a size of
// zero or a full table leaves it unchanged) and executed instruction (pc and word).
// Clear, append and unused op codes leave the unit idle. An executed instruction is
// looked up by scanning the table one entry per cycle through the single ram port,
// so it occupies the unit for the scan, drain and decide steps and an emit step per
// record (decide only when the table is empty). Each instruction yields at most two
// records: an entry record when pc is a stored start address, then an exit record
// when the word is jalr x0,0(x1); both name the first function whose range holds
// pc and the second carries tlast. A result waiting in the output register does
// not stop the next request from being taken. After RECORD_LIMIT records since the
// last clear, further records are dropped.

module function_call_trace_unit
  import fctu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128,
  parameter int RECORD_LIMIT  = 128
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pc[63:0], inst[95:64], func_start[159:96], func_length[223:160]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // record stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // func_index[6:0], record_pc[70:7], call_level[77:71], zero[79:78]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // kind[0]
  output logic                        m_axis_tuser,
  // last record of this instruction
  output logic                        m_axis_tlast
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  fctu_cmd_t           cmd;
  fctu_sts_t           sts;
  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_addr;
  logic [2*ADDR_W-1:0] ram_wdata, ram_rdata;
  logic                out_valid;
  fctu_rec_t           out_rec;

  // sequencer: idle, scan, drain, decide, emit
  fctu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // counters, range compare and result register
  fctu_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .RECORD_LIMIT  (RECORD_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_valid_i  (s_axis_tvalid),
    .req_op_i     (s_axis_tuser),
    .req_pc_i     (s_axis_tdata[63:0]),
    .req_inst_i   (s_axis_tdata[95:64]),
    .req_start_i  (s_axis_tdata[159:96]),
    .req_length_i (s_axis_tdata[223:160]),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid),
    .out_rec_o    (out_rec),
    .out_ready_i  (m_axis_tready)
  );

  // function table: length in the upper half, start address in the lower
  fctu_ram #(
    .WIDTH (2 * ADDR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = cmd.ready;

  // output packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_rec.call_level, out_rec.record_pc, out_rec.func_index};
  assign m_axis_tuser  = out_rec.kind;
  assign m_axis_tlast  = out_rec.last;

endmodule

`default_nettype wire
